FILE: sv/ms_to_time_string_formatter_unit_macros.svh
// ----------------------------------------------------------------------------
// ms_to_time_string_formatter_unit_macros
// Assertion macros for the millisecond time formatter. They expect clk and
// rst in the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef MS_TO_TIME_STRING_FORMATTER_UNIT_MACROS_SVH
`define MS_TO_TIME_STRING_FORMATTER_UNIT_MACROS_SVH

// same-cycle implication
`define MTSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mtsf_pkg.sv
// ----------------------------------------------------------------------------
// mtsf_pkg
// Shared widths, constants and control types of the millisecond formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsf_pkg;

  localparam int MS_W        = 32;
  localparam int CHAR_W      = 8;
  localparam int DIV_W       = 22;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int DIGIT_CAP   = 9;
  localparam int DIV_STEPS   = MS_W;
  localparam int FRAC_STEPS  = 4;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int LIM_W       = 4;
  localparam int REG_IDX_W   = 3;
  localparam int REG_DATA_W  = 4;

  localparam int MAX_FRAC_DIGITS_DEF = 9;

  localparam logic [DIV_W-1:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [DIV_W-1:0] MS_PER_MIN  = 22'd60000;
  localparam logic [DIV_W-1:0] MS_PER_SEC  = 22'd1000;
  localparam logic [DIV_W-1:0] MS_PER_ONE  = 22'd1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h58;

  localparam logic [REG_IDX_W-1:0] REG_SHOW_HOURS      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_MINUTES    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_SECONDS    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEAD_DIGITS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAC_DIGITS     = 3'd4;

  typedef struct packed {
    logic load;
    logic frac;
  } div_ctl_t;

  typedef struct packed {
    logic run;
    logic qbit;
  } div_sts_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } bcd_ctl_t;

endpackage

`default_nettype wire

FILE: sv/mtsf_div.sv
// ----------------------------------------------------------------------------
// mtsf_div
// Bit-serial restoring divider. Full mode: 32 steps, quotient bits MSB
// first. Fraction mode: 4 steps for a quotient below 16.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsf_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mtsf_pkg::div_ctl_t                ctl,
  input  wire logic [mtsf_pkg::MS_W-1:0]         dividend,
  input  wire logic [mtsf_pkg::DIV_W-1:0]        divisor,
  output mtsf_pkg::div_sts_t                     sts,
  output logic [mtsf_pkg::FRAC_STEPS-1:0]        quot,
  output logic [mtsf_pkg::DIV_W-1:0]             rem
);

  logic [mtsf_pkg::DIV_W-1:0]     part;
  logic [mtsf_pkg::MS_W-1:0]      shreg;
  logic [mtsf_pkg::DIV_W-1:0]     dvs;
  logic [mtsf_pkg::DIV_CNT_W-1:0] cnt;
  logic [mtsf_pkg::DIV_W:0]       trial;
  logic [mtsf_pkg::DIV_W:0]       diff;
  logic                           ge;

  always_comb begin
    trial = {part, shreg[mtsf_pkg::MS_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= ctl.frac ? mtsf_pkg::DIV_CNT_W'(mtsf_pkg::FRAC_STEPS)
                      : mtsf_pkg::DIV_CNT_W'(mtsf_pkg::DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - mtsf_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvs <= divisor;
      if (ctl.frac) begin
        part  <= dividend[mtsf_pkg::DIV_W+mtsf_pkg::FRAC_STEPS-1:mtsf_pkg::FRAC_STEPS];
        shreg <= {dividend[mtsf_pkg::FRAC_STEPS-1:0],
                  {(mtsf_pkg::MS_W-mtsf_pkg::FRAC_STEPS){1'b0}}};
      end else begin
        part  <= '0;
        shreg <= dividend;
      end
    end else if (cnt != '0) begin
      part  <= ge ? diff[mtsf_pkg::DIV_W-1:0] : trial[mtsf_pkg::DIV_W-1:0];
      shreg <= {shreg[mtsf_pkg::MS_W-2:0], ge};
    end
  end

  assign sts.run  = (cnt != '0);
  assign sts.qbit = ge;
  assign quot     = shreg[mtsf_pkg::FRAC_STEPS-1:0];
  assign rem      = part;

endmodule

`default_nettype wire

FILE: sv/mtsf_bcd.sv
// ----------------------------------------------------------------------------
// mtsf_bcd
// Serial binary to BCD converter (shift and add-3), one bit per cycle while shift is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsf_bcd (
  input  wire logic                                   clk,
  input  wire mtsf_pkg::bcd_ctl_t                     ctl,
  output logic [mtsf_pkg::NUM_DIGITS-1:0][3:0]        digits
);

  logic [mtsf_pkg::NUM_DIGITS-1:0][3:0] adj;

  always_comb begin
    for (int i = 0; i < mtsf_pkg::NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digits <= '0;
    end else if (ctl.shift) begin
      digits[0] <= {adj[0][2:0], ctl.bit_in};
      for (int i = 1; i < mtsf_pkg::NUM_DIGITS; i++) begin
        digits[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ms_to_time_string_formatter_unit.sv
// ----------------------------------------------------------------------------
// ms_to_time_string_formatter_unit
// Formats a millisecond count as an ASCII string: raw count, or hours,
// minutes and seconds fields with an optional fraction.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low; ms_value is
//   sampled then. The string comes out one character per strobe cycle on
//   out_char, last_char marks the final one and exceeded rides with it.
//   The receiver cannot stall; characters are never held back.
//   Registers are written through wr_en / wr_index / wr_data by the user only while idle; not enforced.
// Sequence:
//   Each decimal field takes a pass through the serial divider (one
//   quotient bit per cycle, fed straight into the BCD shifter), then its
//   digits, plus a separator before the next field. Fields after an
//   exceeded one are X characters and skip the divider. The fraction is a
//   dot, then one 4-step divider pass per digit; one request at a time.
// Reset:
//   rst clears the sequencer and restores the register defaults
//   (all fields shown, no digit limit, no fraction).
// ----------------------------------------------------------------------------
`default_nettype none
`include "ms_to_time_string_formatter_unit_macros.svh"

module ms_to_time_string_formatter_unit #(
  parameter int MAX_FRAC_DIGITS = mtsf_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [mtsf_pkg::MS_W-1:0]           ms_value,
  output logic                                     busy,
  input  wire logic                                wr_en,
  input  wire logic [mtsf_pkg::REG_IDX_W-1:0]      wr_index,
  input  wire logic [mtsf_pkg::REG_DATA_W-1:0]     wr_data,
  output logic                                     strobe,
  output logic [mtsf_pkg::CHAR_W-1:0]              out_char,
  output logic                                     last_char,
  output logic                                     exceeded
);

  localparam int FCW = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int DW  = mtsf_pkg::DIGIT_IDX_W;
  localparam int LW  = mtsf_pkg::LIM_W;

  typedef enum logic [1:0] {F_RAW, F_HOUR, F_MIN, F_SEC} field_t;
  typedef enum logic [2:0] {S_IDLE, S_OPEN, S_DIV, S_DIG, S_XS, S_SEP, S_DOT} state_t;

  function automatic logic [mtsf_pkg::DIV_W-1:0] unit_of(input field_t f);
    logic [mtsf_pkg::DIV_W-1:0] u;
    case (f)
      F_HOUR:  u = mtsf_pkg::MS_PER_HOUR;
      F_MIN:   u = mtsf_pkg::MS_PER_MIN;
      F_SEC:   u = mtsf_pkg::MS_PER_SEC;
      default: u = mtsf_pkg::MS_PER_ONE;
    endcase
    return u;
  endfunction

  // config registers
  logic          show_hours;
  logic          show_minutes;
  logic          show_seconds;
  logic [LW-1:0] max_lead_digits;
  logic [3:0]    frac_digits;

  // sequencer
  state_t                    state;
  field_t                    field;
  logic [mtsf_pkg::MS_W-1:0] work;
  logic [LW-1:0]             lim;
  logic                      ex;
  logic                      fmode;
  logic                      xfrac;
  logic [DW-1:0]             idx;
  logic [3:0]                xcnt;
  logic [FCW-1:0]            fcnt;

  // datapath links
  mtsf_pkg::div_ctl_t                   dctl;
  mtsf_pkg::div_sts_t                   dsts;
  mtsf_pkg::bcd_ctl_t                   bctl;
  logic [mtsf_pkg::MS_W-1:0]            dividend;
  logic [mtsf_pkg::MS_W-1:0]            frac_base;
  logic [mtsf_pkg::FRAC_STEPS-1:0]      div_quot;
  logic [mtsf_pkg::DIV_W-1:0]           div_rem;
  logic [mtsf_pkg::NUM_DIGITS-1:0][3:0] digits;

  // decode
  logic           show_min_eff;
  logic           has_next;
  field_t         next_field;
  field_t         first_field;
  logic           frac_follow;
  logic           field_last;
  logic           x_last;
  state_t         end_state;
  logic [FCW-1:0] fd;
  logic [DW-1:0]  hi;
  logic [DW-1:0]  st;
  logic [LW-1:0]  ndc;
  logic           ex_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      show_hours      <= 1'b1;
      show_minutes    <= 1'b1;
      show_seconds    <= 1'b1;
      max_lead_digits <= '0;
      frac_digits     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        mtsf_pkg::REG_SHOW_HOURS:      show_hours      <= wr_data[0];
        mtsf_pkg::REG_SHOW_MINUTES:    show_minutes    <= wr_data[0];
        mtsf_pkg::REG_SHOW_SECONDS:    show_seconds    <= wr_data[0];
        mtsf_pkg::REG_MAX_LEAD_DIGITS: max_lead_digits <= wr_data;
        mtsf_pkg::REG_FRAC_DIGITS:     frac_digits     <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    show_min_eff = show_minutes | (show_hours & show_seconds);
    fd = (frac_digits > 4'(MAX_FRAC_DIGITS)) ? FCW'(MAX_FRAC_DIGITS) : FCW'(frac_digits);

    if (!show_hours && !show_minutes && !show_seconds) begin
      first_field = F_RAW;
    end else if (show_hours) begin
      first_field = F_HOUR;
    end else if (show_min_eff) begin
      first_field = F_MIN;
    end else begin
      first_field = F_SEC;
    end

    has_next   = 1'b0;
    next_field = field;
    case (field)
      F_HOUR: begin
        if (show_min_eff) begin
          has_next   = 1'b1;
          next_field = F_MIN;
        end else if (show_seconds) begin
          has_next   = 1'b1;
          next_field = F_SEC;
        end
      end
      F_MIN: begin
        if (show_seconds) begin
          has_next   = 1'b1;
          next_field = F_SEC;
        end
      end
      default: ;
    endcase

    frac_follow = (fd != '0) && (field != F_RAW);
    field_last  = !has_next && !frac_follow;
    x_last      = (xcnt == 4'd1) && (xfrac || field_last);

    if (has_next) begin
      end_state = S_SEP;
    end else if (frac_follow) begin
      end_state = S_DOT;
    end else begin
      end_state = S_IDLE;
    end

    // leading digit position of the converted field
    hi = '0;
    for (int i = 0; i < mtsf_pkg::NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        hi = DW'(i);
      end
    end
    ndc    = (hi >= DW'(mtsf_pkg::DIGIT_CAP - 1)) ? LW'(mtsf_pkg::DIGIT_CAP)
                                                : LW'(hi) + LW'(1);
    ex_now = (lim != '0) && (ndc > lim);
    st     = (hi == '0) ? DW'(1) : hi;
  end

  always_comb begin
    dctl.load = ((state == S_OPEN || state == S_DOT) && !ex) ||
                (state == S_DIV && !dsts.run && fmode && fcnt != FCW'(1));
    dctl.frac = (state != S_OPEN);
    frac_base = (state == S_DIV) ? mtsf_pkg::MS_W'(div_rem) : work;
    dividend  = dctl.frac ? (frac_base << 3) + (frac_base << 1) : work;

    bctl.clear  = (state == S_OPEN) && !ex;
    bctl.shift  = dsts.run && !fmode;
    bctl.bit_in = dsts.qbit;
  end

  mtsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dctl),
    .dividend (dividend),
    .divisor  (unit_of(field)),
    .sts      (dsts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  mtsf_bcd u_bcd (
    .clk    (clk),
    .ctl    (bctl),
    .digits (digits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      ex     <= 1'b0;
      fmode  <= 1'b0;
      xfrac  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            work  <= ms_value;
            lim   <= max_lead_digits;
            ex    <= 1'b0;
            field <= first_field;
            state <= S_OPEN;
          end
        end
        S_OPEN: begin
          if (ex) begin
            xcnt  <= 4'd2;
            xfrac <= 1'b0;
            state <= S_XS;
          end else begin
            fmode <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!dsts.run) begin
            work <= mtsf_pkg::MS_W'(div_rem);
            if (fmode) begin
              strobe    <= 1'b1;
              out_char  <= mtsf_pkg::CHAR_ZERO + {4'd0, div_quot};
              last_char <= (fcnt == FCW'(1));
              exceeded  <= 1'b0;
              if (fcnt == FCW'(1)) begin
                state <= S_IDLE;
              end else begin
                fcnt <= fcnt - FCW'(1);
              end
            end else begin
              lim <= '0;
              if (ex_now) begin
                ex    <= 1'b1;
                xcnt  <= lim;
                xfrac <= 1'b0;
                state <= S_XS;
              end else begin
                idx   <= st;
                state <= S_DIG;
              end
            end
          end
        end
        S_DIG: begin
          strobe    <= 1'b1;
          out_char  <= mtsf_pkg::CHAR_ZERO + {4'd0, digits[idx]};
          last_char <= (idx == '0) && field_last;
          exceeded  <= 1'b0;
          if (idx == '0) begin
            state <= end_state;
            if (has_next) begin
              field <= next_field;
            end
          end else begin
            idx <= idx - DW'(1);
          end
        end
        S_XS: begin
          strobe    <= 1'b1;
          out_char  <= mtsf_pkg::CHAR_X;
          last_char <= x_last;
          exceeded  <= x_last && ex;
          xcnt      <= xcnt - 4'd1;
          if (xcnt == 4'd1) begin
            if (xfrac) begin
              state <= S_IDLE;
            end else begin
              state <= end_state;
              if (has_next) begin
                field <= next_field;
              end
            end
          end
        end
        S_SEP: begin
          strobe    <= 1'b1;
          out_char  <= mtsf_pkg::CHAR_COLON;
          last_char <= 1'b0;
          exceeded  <= 1'b0;
          state     <= S_OPEN;
        end
        S_DOT: begin
          strobe    <= 1'b1;
          out_char  <= mtsf_pkg::CHAR_DOT;
          last_char <= 1'b0;
          exceeded  <= 1'b0;
          if (ex) begin
            xcnt  <= 4'(fd);
            xfrac <= 1'b1;
            state <= S_XS;
          end else begin
            fmode <= 1'b1;
            fcnt  <= fd;
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `MTSF_ASSERT_NOW(a_last_ends_request, strobe && last_char, !busy, "busy after last character")
  `MTSF_ASSERT_NOW(a_exceeded_on_last, strobe && exceeded, last_char, "exceeded without last")
  `MTSF_ASSERT_NEXT(a_start_takes, start && !busy, busy, "request not taken")
  `MTSF_ASSERT_NOW(a_div_idle_on_digits, state == S_DIG, !dsts.run, "divider active on digits")

endmodule

`default_nettype wire

FILE: test/ms_to_time_string_formatter_unit_checker.sv
// ----------------------------------------------------------------------------
// ms_to_time_string_formatter_unit_checker
// Watches the request, register and character ports of the millisecond
// formatter. It keeps its own copy of the registers and builds the expected
// string of every accepted request. Each strobed character is then compared
// against it, one character at a time.
// ----------------------------------------------------------------------------
module ms_to_time_string_formatter_unit_checker
  import mtsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [MS_W-1:0]       ms_value,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data,
  input  logic                  strobe,
  input  logic [CHAR_W-1:0]     out_char,
  input  logic                  last_char,
  input  logic                  exceeded,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS = 20;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              over;
    logic [MS_W-1:0]   src;
  } char_exp_t;

  char_exp_t         char_q[$];
  logic [CHAR_W-1:0] text_q[$];

  logic             show_hr    = 1'b1;
  logic             show_min   = 1'b1;
  logic             show_sec   = 1'b1;
  logic [LIM_W-1:0] lead_limit = '0;
  logic [LIM_W-1:0] frac_len   = '0;

  int err_count   = 0;
  int outstanding = 0;

  assign mismatches = err_count;
  assign pending    = outstanding;

  task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                 input logic [CHAR_W-1:0] want,
                                 input logic [MS_W-1:0] src);
    $display("%0t: ms_value %0d: %s got %h want %h", $time, src, what, got, want);
    err_count++;
  endtask

  // decimal field, two digits minimum; X characters when over the limit
  function automatic bit emit_field(input logic [MS_W-1:0] value, input int unsigned limit);
    int unsigned       digits;
    longint unsigned   scale;
    logic [MS_W-1:0]   rest;
    logic [CHAR_W-1:0] dig_q[$];
    logic [CHAR_W-1:0] d;
    if (limit > 0) begin
      digits = 1;
      for (scale = 10; value >= scale && scale != 1000000000; scale = scale * 10) begin
        digits++;
        if (digits > limit) begin
          repeat (limit) text_q.push_back(CHAR_X);
          return 1'b1;
        end
      end
    end
    rest = value;
    do begin
      d = CHAR_ZERO + CHAR_W'(rest % 10);
      dig_q.push_front(d);
      rest = rest / 10;
    end while (rest != 0);
    if (dig_q.size() < 2) dig_q.push_front(CHAR_ZERO);
    foreach (dig_q[i]) text_q.push_back(dig_q[i]);
    return 1'b0;
  endfunction

  function automatic void predict_string(input logic [MS_W-1:0] ms_in);
    logic [MS_W-1:0]   rem;
    logic [MS_W-1:0]   unit;
    logic [CHAR_W-1:0] d;
    int unsigned       lim;
    int unsigned       fd;
    bit                over;
    char_exp_t         e;
    text_q.delete();
    rem  = ms_in;
    lim  = 32'(lead_limit);
    unit = '0;
    fd   = (frac_len > MAX_FRAC_DIGITS_DEF) ? MAX_FRAC_DIGITS_DEF : 32'(frac_len);
    over = 1'b0;
    if (!show_hr && !show_min && !show_sec) over = emit_field(rem, lim);
    if (show_hr) begin
      unit = MS_W'(MS_PER_HOUR);
      over = emit_field(rem / unit, lim);
      rem  = rem % unit;
      lim  = 0;
    end
    if (show_min || (show_hr && show_sec)) begin
      if (text_q.size() > 0) text_q.push_back(CHAR_COLON);
      unit = MS_W'(MS_PER_MIN);
      if (over) begin
        text_q.push_back(CHAR_X);
        text_q.push_back(CHAR_X);
      end else begin
        over = emit_field(rem / unit, lim);
        rem  = rem % unit;
        lim  = 0;
      end
    end
    if (show_sec) begin
      if (text_q.size() > 0) text_q.push_back(CHAR_COLON);
      unit = MS_W'(MS_PER_SEC);
      if (over) begin
        text_q.push_back(CHAR_X);
        text_q.push_back(CHAR_X);
      end else begin
        over = emit_field(rem / unit, lim);
        rem  = rem % unit;
        lim  = 0;
      end
    end
    if (fd > 0 && unit != 0) begin
      text_q.push_back(CHAR_DOT);
      repeat (fd) begin
        if (over) begin
          text_q.push_back(CHAR_X);
        end else begin
          rem = rem * 10;
          d   = CHAR_ZERO + CHAR_W'((rem / unit) % 10);
          text_q.push_back(d);
          rem = rem % unit;
        end
      end
    end
    while (text_q.size() > MAX_CHARS) void'(text_q.pop_back());
    foreach (text_q[i]) begin
      e.ch   = text_q[i];
      e.last = (i == text_q.size() - 1);
      e.over = e.last && over;
      e.src  = ms_in;
      char_q.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    char_exp_t e;
    if (rst) begin
      show_hr    = 1'b1;
      show_min   = 1'b1;
      show_sec   = 1'b1;
      lead_limit = '0;
      frac_len   = '0;
      char_q.delete();
    end else begin
      if (strobe) begin
        if (char_q.size() == 0) begin
          report_mismatch("unexpected char", out_char, '0, '0);
        end else begin
          e = char_q.pop_front();
          if (out_char !== e.ch) report_mismatch("out_char", out_char, e.ch, e.src);
          if (last_char !== e.last) begin
            report_mismatch("last_char", CHAR_W'(last_char), CHAR_W'(e.last), e.src);
          end
          if (exceeded !== e.over) begin
            report_mismatch("exceeded", CHAR_W'(exceeded), CHAR_W'(e.over), e.src);
          end
        end
      end
      if (start && !busy) predict_string(ms_value);
      if (wr_en) begin
        case (wr_index)
          REG_SHOW_HOURS:      show_hr    = wr_data[0];
          REG_SHOW_MINUTES:    show_min   = wr_data[0];
          REG_SHOW_SECONDS:    show_sec   = wr_data[0];
          REG_MAX_LEAD_DIGITS: lead_limit = wr_data;
          REG_FRAC_DIGITS:     frac_len   = wr_data;
          default: ;
        endcase
      end
    end
    outstanding = char_q.size();
  end

endmodule

FILE: test/tb_ms_to_time_string_formatter_unit.sv
// ----------------------------------------------------------------------------
// tb_ms_to_time_string_formatter_unit
// Drives millisecond counts into the formatter under a series of register
// settings: a directed set of corner values and field layouts first, then
// random phases with random layouts, digit limits and fraction lengths.
// Request gaps are random. The checker beside the block predicts every
// character; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ms_to_time_string_formatter_unit;
  import mtsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 350;

  localparam logic [MS_W-1:0] CORNER_MS [10] = '{
    32'd0, 32'hFFFF_FFFF, 32'd3599999, 32'd3600000, 32'd59999,
    32'd60000, 32'd999, 32'd1000, 32'h8000_0000, 32'h7FFF_FFFF
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  start    = 1'b0;
  logic [MS_W-1:0]       ms_value = '0;
  logic                  wr_en    = 1'b0;
  logic [REG_IDX_W-1:0]  wr_index = '0;
  logic [REG_DATA_W-1:0] wr_data  = '0;
  logic                  busy;
  logic                  strobe;
  logic [CHAR_W-1:0]     out_char;
  logic                  last_char;
  logic                  exceeded;
  int                    mismatches;
  int                    pending;

  int cycle_cnt = 0;
  bit idle_on   = 1'b1;

  ms_to_time_string_formatter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .ms_value  (ms_value),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .strobe    (strobe),
    .out_char  (out_char),
    .last_char (last_char),
    .exceeded  (exceeded)
  );

  ms_to_time_string_formatter_unit_checker i_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .ms_value   (ms_value),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .strobe     (strobe),
    .out_char   (out_char),
    .last_char  (last_char),
    .exceeded   (exceeded),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_ms_to_time_string_formatter_unit NOT OK");
      $finish;
    end
  end

  // request held until the block takes it
  task automatic send_request(input logic [MS_W-1:0] v);
    start    <= 1'b1;
    ms_value <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 150);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic put_request(input logic [MS_W-1:0] v);
    send_request(v);
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
  endtask

  // unused upper data bits of the flag registers get random values
  task automatic set_config(input bit h, input bit m, input bit s,
                            input logic [LIM_W-1:0] lim, input logic [LIM_W-1:0] frac);
    drain();
    write_reg(REG_SHOW_HOURS, {3'($urandom), h});
    write_reg(REG_SHOW_MINUTES, {3'($urandom), m});
    write_reg(REG_SHOW_SECONDS, {3'($urandom), s});
    write_reg(REG_MAX_LEAD_DIGITS, lim);
    write_reg(REG_FRAC_DIGITS, frac);
    wr_en <= 1'b0;
  endtask

  task automatic random_config();
    int r;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] frac;
    r = $urandom_range(0, 99);
    if (r < 25) lim = '0;
    else if (r < 40) lim = 4'd10;
    else if (r < 50) lim = LIM_W'($urandom_range(11, 15));
    else lim = LIM_W'($urandom_range(1, 9));
    r = $urandom_range(0, 99);
    if (r < 30) frac = '0;
    else if (r < 45) frac = 4'd9;
    else if (r < 55) frac = LIM_W'($urandom_range(10, 15));
    else frac = LIM_W'($urandom_range(1, 8));
    set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), lim, frac);
  endtask

  function automatic logic [MS_W-1:0] rand_ms();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2, 3:    return $urandom_range(0, 999);
      4, 5:    return $urandom_range(0, 3599999);
      6:       return $urandom_range(0, 359999999);
      7:       return $urandom >> $urandom_range(0, 31);
      default: return CORNER_MS[$urandom_range(0, 9)];
    endcase
  endfunction

  initial begin
    int sent;
    int phase_len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset layout HH:MM:SS, no limit, no fraction
    put_request(32'd0);
    put_request(32'd999);
    put_request(32'd60000);
    put_request(32'd3599999);
    put_request(32'hFFFF_FFFF);
    put_request(32'h8000_0000);
    // raw count
    set_config(0, 0, 0, 0, 0);
    put_request(32'd7);
    put_request(32'hFFFF_FFFF);
    // ten digits pass a nine-digit limit
    set_config(0, 0, 0, 9, 5);
    put_request(32'hFFFF_FFFF);
    set_config(0, 0, 0, 3, 0);
    put_request(32'd12345);
    // hours and seconds force minutes
    set_config(1, 0, 1, 1, 9);
    put_request(32'd43200000);
    put_request(32'd5);
    // saturated fraction length, unreachable limit
    set_config(0, 0, 1, 15, 15);
    put_request(32'hFFFF_FFFF);
    put_request(32'd1234);
    set_config(0, 1, 0, 0, 3);
    put_request(32'd59999);
    set_config(1, 0, 0, 10, 9);
    put_request(32'hFFFF_FFFF);
    set_config(0, 1, 1, 2, 2);
    put_request(32'd6000000);
    put_request(32'd5999999);
    set_config(1, 1, 0, 3, 1);
    put_request(32'hFFFF_FFFF);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_config();
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(10, 28);
      repeat (phase_len) begin
        put_request(rand_ms());
        sent++;
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_ms_to_time_string_formatter_unit OK");
    end else begin
      $display("tb_ms_to_time_string_formatter_unit NOT OK");
    end
    $finish;
  end

endmodule
